// ===== design/hfcp_pkg.sv =====
package hfcp_pkg;

    // Longest run of results one frame may produce
    localparam int RUN_CAP = 64;
    localparam int IDX_W   = 6;
    localparam int LEN_W   = 7;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0]       SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]       SYNC_SECOND_RST = 8'h55;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 7'd64;

    typedef struct packed {
        logic [7:0]       frame_type;
        logic [LEN_W-1:0] frame_length;
    } frame_desc_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

endpackage

// ===== design/header_frame_checksum_parser.sv =====
// Sync / type / length / checksum frame parser.
// Input channel (s_valid, s_ready, s_rx_byte) takes one received serial byte
// per transfer. The front end hunts for the two sync bytes, takes type and
// length, writes payload bytes into the payload store and checks the
// 8-bit wrapping sum against the checksum byte. A passing frame goes into a
// two-entry frame queue; the back end replays it on the result channel
// (m_valid, m_ready, m_*) as one transfer per payload byte, last on the
// final one, or as a single transfer with has_byte low for an empty frame.
// Header and sync bytes are taken one per cycle, the checksum byte too while
// the queue has room. Payload bytes of a new frame are held off while an
// earlier frame still drains from the store. Each payload result is read
// through the fetch and load states, set by the store's registered read
// port; the next read starts only once the receiver takes the result. A
// stalled receiver holds the result steady and, once the queue fills, holds
// off the next checksum byte.
// Configuration (cfg_we, cfg_index, cfg_data) writes sync_first, sync_second
// or max_payload by cfg_index. Synchronous reset puts the parser in the
// hunt, empties the queue and restores register defaults; the store keeps
// its contents.
module header_frame_checksum_parser #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_frame_type,
    output logic [hfcp_pkg::LEN_W-1:0] m_frame_length,
    output logic [hfcp_pkg::IDX_W-1:0] m_byte_index,
    output logic [7:0]                 m_payload_byte,
    output logic                       m_has_byte,
    output logic                       m_last
);
    import hfcp_pkg::*;

    logic             drain_busy;
    logic             queue_full;
    logic             push;
    frame_desc_t      push_desc;
    store_wr_t        store_wr;
    logic             q_pop;
    frame_desc_t      q_desc;
    logic             q_not_empty;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    hfcp_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .drain_busy (drain_busy),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc),
        .store_wr   (store_wr)
    );

    hfcp_store #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_store (
        .aclk    (aclk),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hfcp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (q_pop),
        .pop_desc  (q_desc),
        .not_empty (q_not_empty)
    );

    hfcp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_not_empty    (q_not_empty),
        .q_desc         (q_desc),
        .q_pop          (q_pop),
        .drain_busy     (drain_busy),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_type   (m_frame_type),
        .m_frame_length (m_frame_length),
        .m_byte_index   (m_byte_index),
        .m_payload_byte (m_payload_byte),
        .m_has_byte     (m_has_byte),
        .m_last         (m_last)
    );

endmodule

// ===== design/hfcp_store.sv =====
module hfcp_store #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                     aclk,
    input  hfcp_pkg::store_wr_t      wr,
    input  logic [hfcp_pkg::IDX_W-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    import hfcp_pkg::*;

    localparam int STORE_DEPTH = (BUFFER_DEPTH < RUN_CAP) ? BUFFER_DEPTH : RUN_CAP;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/hfcp_queue.sv =====
module hfcp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hfcp_pkg::frame_desc_t push_desc,
    output logic                  full,
    input  logic                  pop,
    output hfcp_pkg::frame_desc_t pop_desc,
    output logic                  not_empty
);
    import hfcp_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    frame_desc_t      entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_desc  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                entry_reg[wr_ptr_reg] <= push_desc;
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push && !full, pop && not_empty})
                2'b10:   count_reg <= count_reg + (PW+1)'(1);
                2'b01:   count_reg <= count_reg - (PW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/hfcp_front.sv =====
module hfcp_front #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  logic                  drain_busy,
    input  logic                  queue_full,
    output logic                  push,
    output hfcp_pkg::frame_desc_t push_desc,
    output hfcp_pkg::store_wr_t   store_wr
);
    import hfcp_pkg::*;

    localparam logic [7:0] LEN_CAP =
        8'((BUFFER_DEPTH < RUN_CAP) ? BUFFER_DEPTH : RUN_CAP);

    typedef enum logic [2:0] {
        PH_SYNC1, PH_SYNC2, PH_TYPE, PH_LEN, PH_DATA, PH_CHECK
    } phase_t;

    phase_t           phase_reg;
    logic [7:0]       sync_first_reg;
    logic [7:0]       sync_second_reg;
    logic [LEN_W-1:0] max_payload_reg;
    logic [7:0]       held_type_reg;
    logic [LEN_W-1:0] held_length_reg;
    logic [LEN_W-1:0] fill_count_reg;
    logic [7:0]       running_sum_reg;

    logic [7:0]       len_limit;
    logic [LEN_W-1:0] fill_next;
    logic             accept;

    always_comb begin
        len_limit = {1'b0, max_payload_reg};
        if (len_limit > LEN_CAP) begin
            len_limit = LEN_CAP;
        end
    end

    // Hold payload bytes while the back end still reads the store,
    // and hold the checksum byte while the queue has no room.
    assign s_ready = !((phase_reg == PH_DATA) && drain_busy)
                  && !((phase_reg == PH_CHECK) && queue_full);
    assign accept    = s_valid && s_ready;
    assign fill_next = fill_count_reg + LEN_W'(1);

    assign store_wr.en   = accept && (phase_reg == PH_DATA);
    assign store_wr.addr = fill_count_reg[IDX_W-1:0];
    assign store_wr.data = s_rx_byte;

    assign push = accept && (phase_reg == PH_CHECK) && (s_rx_byte == running_sum_reg);
    assign push_desc.frame_type   = held_type_reg;
    assign push_desc.frame_length = held_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
            phase_reg       <= PH_SYNC1;
            held_type_reg   <= '0;
            held_length_reg <= '0;
            fill_count_reg  <= '0;
            running_sum_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                    CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                    CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                case (phase_reg)
                    PH_SYNC1: begin
                        if (s_rx_byte == sync_first_reg) begin
                            phase_reg <= PH_SYNC2;
                        end
                    end
                    PH_SYNC2: begin
                        phase_reg <= (s_rx_byte == sync_second_reg) ? PH_TYPE : PH_SYNC1;
                    end
                    PH_TYPE: begin
                        held_type_reg <= s_rx_byte;
                        phase_reg     <= PH_LEN;
                    end
                    PH_LEN: begin
                        if (s_rx_byte > len_limit) begin
                            phase_reg <= PH_SYNC1;
                        end else begin
                            held_length_reg <= s_rx_byte[LEN_W-1:0];
                            fill_count_reg  <= '0;
                            running_sum_reg <= held_type_reg + s_rx_byte;
                            phase_reg <= (s_rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
                        end
                    end
                    PH_DATA: begin
                        fill_count_reg  <= fill_next;
                        running_sum_reg <= running_sum_reg + s_rx_byte;
                        if (fill_next >= held_length_reg) begin
                            phase_reg <= PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        phase_reg <= PH_SYNC1;
                    end
                    default: phase_reg <= PH_SYNC1;
                endcase
            end
        end
    end

endmodule

// ===== design/hfcp_back.sv =====
module hfcp_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_not_empty,
    input  hfcp_pkg::frame_desc_t      q_desc,
    output logic                       q_pop,
    output logic                       drain_busy,
    output logic [hfcp_pkg::IDX_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_frame_type,
    output logic [hfcp_pkg::LEN_W-1:0] m_frame_length,
    output logic [hfcp_pkg::IDX_W-1:0] m_byte_index,
    output logic [7:0]                 m_payload_byte,
    output logic                       m_has_byte,
    output logic                       m_last
);
    import hfcp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE, ST_FETCH, ST_LOAD, ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [7:0]       type_reg;
    logic [LEN_W-1:0] len_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             valid_reg;
    logic [7:0]       payload_reg;
    logic             has_byte_reg;
    logic             last_reg;

    assign q_pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign drain_busy = (state_reg != ST_IDLE) || q_not_empty;
    assign rd_addr    = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_not_empty) begin
                        type_reg <= q_desc.frame_type;
                        len_reg  <= q_desc.frame_length;
                        idx_reg  <= '0;
                        if (q_desc.frame_length == '0) begin
                            payload_reg  <= '0;
                            has_byte_reg <= 1'b0;
                            last_reg     <= 1'b1;
                            valid_reg    <= 1'b1;
                            state_reg    <= ST_EMIT;
                        end else begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                // store read data lands at the end of this cycle
                ST_FETCH: state_reg <= ST_LOAD;
                ST_LOAD: begin
                    payload_reg  <= rd_data;
                    has_byte_reg <= 1'b1;
                    last_reg     <= ({1'b0, idx_reg} + LEN_W'(1)) == len_reg;
                    valid_reg    <= 1'b1;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        valid_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid        = valid_reg;
    assign m_frame_type   = type_reg;
    assign m_frame_length = len_reg;
    assign m_byte_index   = idx_reg;
    assign m_payload_byte = payload_reg;
    assign m_has_byte     = has_byte_reg;
    assign m_last         = last_reg;

endmodule
